>>> hw/rtl/cbm_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Cartridge bank mapper package
// Shared types, codes and constants of the cartridge bank mapper.
// ----------------------------------------------------------------------------
package cbm_pkg;

  // Fixed field widths.
  localparam int unsigned OpW       = 2;
  localparam int unsigned AddrW     = 16;
  localparam int unsigned ByteW     = 8;
  localparam int unsigned BankW     = 7;
  localparam int unsigned RamBankW  = 2;
  localparam int unsigned SizeW     = 2;
  localparam int unsigned TargetW   = 2;
  localparam int unsigned MapW      = 21;
  localparam int unsigned RomOffW   = 14;  // 16 KB ROM bank
  localparam int unsigned RamSmallW = 11;  // 2 KB RAM
  localparam int unsigned RamBigW   = 13;  // 8 KB RAM bank

  // Configuration register map, selected by paddr[2].
  localparam int unsigned PaddrW   = 3;
  localparam int unsigned PdataW   = 32;
  localparam logic        RegRomMask = 1'b0;
  localparam logic        RegRamSize = 1'b1;

  // Register reset values.
  localparam logic [BankW-1:0] RomMaskReset = 7'd1;
  localparam logic [SizeW-1:0] RamSizeReset = 2'd0;

  // Control write field values.
  localparam logic [3:0] RamEnableKey = 4'hA;
  localparam logic [6:0] UpperBankBits = 7'b1100000;

  // Bus access kinds.
  typedef enum logic [OpW-1:0] {
    OP_ROM_READ   = 2'd0,
    OP_CTRL_WRITE = 2'd1,
    OP_RAM_READ   = 2'd2,
    OP_RAM_WRITE  = 2'd3
  } op_e;

  // Where a mapped access goes.
  typedef enum logic [TargetW-1:0] {
    TGT_NONE = 2'd0,
    TGT_ROM  = 2'd1,
    TGT_RAM  = 2'd2
  } target_e;

  // RAM size codes.
  typedef enum logic [SizeW-1:0] {
    RAM_NONE  = 2'd0,
    RAM_2K    = 2'd1,
    RAM_8K    = 2'd2,
    RAM_32K   = 2'd3
  } ram_size_e;

  // Control write areas, from address bits 14:13.
  typedef enum logic [1:0] {
    CTRL_RAM_ENABLE = 2'd0,
    CTRL_LOW_BANK   = 2'd1,
    CTRL_HIGH_BANK  = 2'd2,
    CTRL_MODE       = 2'd3
  } ctrl_area_e;

  // Configuration seen by the mapping core.
  typedef struct packed {
    logic [BankW-1:0] rom_bank_mask;
    ram_size_e        ram_size_code;
  } cfg_t;

  // One mapped result.
  typedef struct packed {
    target_e           target;
    logic [MapW-1:0]   mapped_address;
    logic              ram_write_enable;
    logic [ByteW-1:0]  ram_write_data;
  } result_t;

endpackage
`default_nettype wire

>>> hw/rtl/cbm_map_core.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Cartridge bank mapper core
// Holds the banking state, applies control writes and maps each access.
// ----------------------------------------------------------------------------
module cbm_map_core (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  input  wire                          accept_i,
  input  cbm_pkg::op_e                 operation_i,
  input  wire  [cbm_pkg::AddrW-1:0]    address_i,
  input  wire  [cbm_pkg::ByteW-1:0]    write_value_i,
  input  cbm_pkg::cfg_t                cfg_i,
  output cbm_pkg::result_t             result_o
);

  // Banking state.
  logic [cbm_pkg::BankW-1:0]    bank_select_q, bank_select_d;
  logic [cbm_pkg::RamBankW-1:0] ram_bank_q, ram_bank_d;
  logic [cbm_pkg::BankW-1:0]    rom_bank_q, rom_bank_d;
  logic [cbm_pkg::BankW-1:0]    lower_bank_q, lower_bank_d;
  logic                         adv_mode_q, adv_mode_d;
  logic                         ram_en_q, ram_en_d;

  // Values a control write leaves before the bank recompute.
  logic [cbm_pkg::BankW-1:0]    bs_new;
  logic [cbm_pkg::RamBankW-1:0] rbn_new;
  logic                         mode_new;
  logic                         recompute;
  logic [cbm_pkg::BankW-1:0]    rb_sel;
  logic [4:0]                   low_bits;
  cbm_pkg::ctrl_area_e          area;

  assign area     = cbm_pkg::ctrl_area_e'(address_i[14:13]);
  assign low_bits = (write_value_i[4:0] == 5'd0) ? 5'd1 : write_value_i[4:0];

  // Control write decode.
  always_comb begin
    bs_new    = bank_select_q;
    rbn_new   = ram_bank_q;
    mode_new  = adv_mode_q;
    recompute = 1'b0;
    ram_en_d  = ram_en_q;
    if (accept_i && operation_i == cbm_pkg::OP_CTRL_WRITE && !address_i[15]) begin
      unique case (area)
        cbm_pkg::CTRL_RAM_ENABLE: begin
          ram_en_d = (write_value_i[3:0] == cbm_pkg::RamEnableKey);
        end
        cbm_pkg::CTRL_LOW_BANK: begin
          bs_new    = {bank_select_q[6:5], low_bits};
          recompute = 1'b1;
        end
        cbm_pkg::CTRL_HIGH_BANK: begin
          bs_new    = {write_value_i[1:0], bank_select_q[4:0]};
          rbn_new   = write_value_i[1:0];
          recompute = 1'b1;
        end
        cbm_pkg::CTRL_MODE: begin
          mode_new  = write_value_i[0];
          recompute = 1'b1;
        end
        default: ;
      endcase
    end
  end

  // Bank recompute: mode 1 takes upper ROM bits from the RAM bank before it is
  // clamped; mode 0 clears the RAM bank.
  assign rb_sel = mode_new ? {rbn_new, bs_new[4:0]} : bs_new;

  always_comb begin
    bank_select_d = bank_select_q;
    ram_bank_d    = ram_bank_q;
    rom_bank_d    = rom_bank_q;
    lower_bank_d  = lower_bank_q;
    adv_mode_d    = adv_mode_q;
    if (recompute) begin
      bank_select_d = bs_new;
      adv_mode_d    = mode_new;
      ram_bank_d    = (mode_new && cfg_i.ram_size_code == cbm_pkg::RAM_32K) ?
                      rbn_new : '0;
      rom_bank_d    = rb_sel & cfg_i.rom_bank_mask;
      lower_bank_d  = bs_new & cfg_i.rom_bank_mask & cbm_pkg::UpperBankBits;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bank_select_q <= 7'd1;
      ram_bank_q    <= '0;
      rom_bank_q    <= 7'd1;
      lower_bank_q  <= '0;
      adv_mode_q    <= 1'b0;
      ram_en_q      <= 1'b0;
    end else begin
      bank_select_q <= bank_select_d;
      ram_bank_q    <= ram_bank_d;
      rom_bank_q    <= rom_bank_d;
      lower_bank_q  <= lower_bank_d;
      adv_mode_q    <= adv_mode_d;
      ram_en_q      <= ram_en_d;
    end
  end

  // Address mapping from the state before this access.
  always_comb begin
    result_o = '{target: cbm_pkg::TGT_NONE, mapped_address: '0,
                 ram_write_enable: 1'b0, ram_write_data: '0};
    unique case (operation_i)
      cbm_pkg::OP_ROM_READ: begin
        if (!address_i[15]) begin
          result_o.target = cbm_pkg::TGT_ROM;
          if (!address_i[14]) begin
            result_o.mapped_address = adv_mode_q ?
                {lower_bank_q, address_i[cbm_pkg::RomOffW-1:0]} :
                {{cbm_pkg::BankW{1'b0}}, address_i[cbm_pkg::RomOffW-1:0]};
          end else begin
            result_o.mapped_address = {rom_bank_q, address_i[cbm_pkg::RomOffW-1:0]};
          end
        end
      end
      cbm_pkg::OP_CTRL_WRITE: ;
      cbm_pkg::OP_RAM_READ, cbm_pkg::OP_RAM_WRITE: begin
        if (ram_en_q) begin
          unique case (cfg_i.ram_size_code)
            cbm_pkg::RAM_NONE: ;
            cbm_pkg::RAM_2K: begin
              if (address_i[15:cbm_pkg::RamSmallW] == '0) begin
                result_o.target         = cbm_pkg::TGT_RAM;
                result_o.mapped_address = {8'd0, ram_bank_q,
                                           address_i[cbm_pkg::RamSmallW-1:0]};
              end
            end
            cbm_pkg::RAM_8K, cbm_pkg::RAM_32K: begin
              if (address_i[15:cbm_pkg::RamBigW] == '0) begin
                result_o.target         = cbm_pkg::TGT_RAM;
                result_o.mapped_address = {6'd0, ram_bank_q,
                                           address_i[cbm_pkg::RamBigW-1:0]};
              end
            end
            default: ;
          endcase
          if (result_o.target == cbm_pkg::TGT_RAM &&
              operation_i == cbm_pkg::OP_RAM_WRITE) begin
            result_o.ram_write_enable = 1'b1;
            result_o.ram_write_data   = write_value_i;
          end
        end
      end
      default: ;
    endcase
  end

endmodule
`default_nettype wire

>>> hw/rtl/cartridge_bank_mapper.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Cartridge bank mapper
// Maps cartridge bus accesses to physical ROM/RAM addresses and handles
// bank control writes.
//
// Channel   Direction  Contents
// s_axis    in         tuser: operation; tdata: address, write_value
// m_axis    out        tuser: target; tdata: mapped_address, ram_write_enable,
//                      ram_write_data
// APB       in/out     register 0 rom_bank_mask at 0x0, 1 ram_size_code at 0x4
//
// Each transaction is mapped combinationally; its result lands in the output
// register at the accepting edge. A new transaction is taken every cycle
// unless the output is stalled: the output register is the only stage, and
// when it is full and stalled, s_axis_tready drops until it is taken. Reset
// restores the banking state and registers and clears the output valid flag.
// ----------------------------------------------------------------------------
module cartridge_bank_mapper (
  input  wire                          clk_i,
  input  wire                          rst_ni,
  // Input stream.
  input  wire                          s_axis_tvalid,
  output logic                         s_axis_tready,
  input  wire  [23:0]                  s_axis_tdata,  // [15:0] address, [23:16] write_value
  input  wire  [1:0]                   s_axis_tuser,  // [1:0] operation
  // Output stream.
  output logic                         m_axis_tvalid,
  input  wire                          m_axis_tready,
  output logic [31:0]                  m_axis_tdata,  // [20:0] mapped_address,
                                                      // [21] ram_write_enable,
                                                      // [29:22] ram_write_data
  output logic [1:0]                   m_axis_tuser,  // [1:0] target
  // Configuration port.
  input  wire                          psel,
  input  wire                          penable,
  input  wire                          pwrite,
  input  wire  [cbm_pkg::PaddrW-1:0]   paddr,
  input  wire  [cbm_pkg::PdataW-1:0]   pwdata,
  output logic [cbm_pkg::PdataW-1:0]   prdata,
  output logic                         pready
);

  cbm_pkg::cfg_t    cfg_q;
  cbm_pkg::result_t result;
  cbm_pkg::result_t out_q;
  logic             out_valid_q;
  logic             in_accept;
  logic             cfg_write;

  // Configuration registers.
  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.rom_bank_mask <= cbm_pkg::RomMaskReset;
      cfg_q.ram_size_code <= cbm_pkg::ram_size_e'(cbm_pkg::RamSizeReset);
    end else if (cfg_write) begin
      if (paddr[2] == cbm_pkg::RegRomMask) begin
        cfg_q.rom_bank_mask <= pwdata[cbm_pkg::BankW-1:0];
      end else begin
        cfg_q.ram_size_code <= cbm_pkg::ram_size_e'(pwdata[cbm_pkg::SizeW-1:0]);
      end
    end
  end

  assign prdata = (paddr[2] == cbm_pkg::RegRamSize) ?
                  {{(cbm_pkg::PdataW-cbm_pkg::SizeW){1'b0}}, cfg_q.ram_size_code} :
                  {{(cbm_pkg::PdataW-cbm_pkg::BankW){1'b0}}, cfg_q.rom_bank_mask};

  // Input handshake: accept whenever the output register is free or drains.
  assign s_axis_tready = !out_valid_q || m_axis_tready;
  assign in_accept     = s_axis_tvalid && s_axis_tready;

  cbm_map_core u_core (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .accept_i      (in_accept),
    .operation_i   (cbm_pkg::op_e'(s_axis_tuser)),
    .address_i     (s_axis_tdata[15:0]),
    .write_value_i (s_axis_tdata[23:16]),
    .cfg_i         (cfg_q),
    .result_o      (result)
  );

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      out_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_accept) begin
      out_q <= result;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.target;
  assign m_axis_tdata  = {2'b00, out_q.ram_write_data, out_q.ram_write_enable,
                          out_q.mapped_address};

  // A RAM write only ever goes to RAM.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tdata[21]) |-> (m_axis_tuser == cbm_pkg::TGT_RAM))
    else $error("RAM write enable with a target other than RAM");

  // An unmapped access carries a zero address and no write data.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid && m_axis_tuser == cbm_pkg::TGT_NONE) |->
      (m_axis_tdata == '0))
    else $error("Unmapped access with nonzero payload");

  // Every accepted transaction shows up at the output in the next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_accept |=> m_axis_tvalid)
    else $error("Accepted transaction produced no result");

endmodule
`default_nettype wire
